@@ design/plu_pkg.sv @@
package plu_pkg;

    localparam int REG_COUNT_DEFAULT = 32;
    localparam int DATA_W            = 32;
    localparam int IDX_W             = 5;
    localparam int IMM_W             = 16;
    localparam int CMD_W             = 4;
    localparam int CR_W              = 4;
    localparam int CLZ_W             = 6;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DATA_W-1:0] t_word;
    typedef logic [IMM_W-1:0]  t_imm;
    typedef logic [CR_W-1:0]   t_cr;

    localparam t_cmd CMD_ORI    = 4'd0;
    localparam t_cmd CMD_ORIS   = 4'd1;
    localparam t_cmd CMD_OR     = 4'd2;
    localparam t_cmd CMD_AND    = 4'd3;
    localparam t_cmd CMD_ANDI   = 4'd4;
    localparam t_cmd CMD_ANDIS  = 4'd5;
    localparam t_cmd CMD_NOR    = 4'd6;
    localparam t_cmd CMD_ANDC   = 4'd7;
    localparam t_cmd CMD_XOR    = 4'd8;
    localparam t_cmd CMD_XORI   = 4'd9;
    localparam t_cmd CMD_XORIS  = 4'd10;
    localparam t_cmd CMD_NEG    = 4'd11;
    localparam t_cmd CMD_EXTSH  = 4'd12;
    localparam t_cmd CMD_EXTSB  = 4'd13;
    localparam t_cmd CMD_CNTLZW = 4'd14;

    localparam t_word MOST_NEGATIVE = 32'h8000_0000;

    typedef struct packed {
        t_cmd command;
        t_idx dest_index;
        t_idx first_source;
        t_idx second_source;
        t_imm immediate;
        logic record_flag;
        logic overflow_enable;
    } t_item;

    typedef struct packed {
        t_cr  cr0;
        logic ov;
        logic so;
    } t_flags;

    typedef struct packed {
        t_word  value;
        logic   write_en;
        logic   rec;
        t_flags flags;
    } t_alu_result;

    typedef struct packed {
        t_idx  written_index;
        t_word written_value;
        logic  cr0_written;
        t_cr   cr0_bits;
        logic  overflow_bit;
        logic  summary_overflow_bit;
    } t_result;

endpackage

@@ design/plu_if.sv @@
interface plu_in_if;
    logic           valid;
    logic           ready;
    plu_pkg::t_cmd  command;
    plu_pkg::t_idx  dest_index;
    plu_pkg::t_idx  first_source;
    plu_pkg::t_idx  second_source;
    plu_pkg::t_imm  immediate;
    logic           record_flag;
    logic           overflow_enable;

    modport source (
        output valid, command, dest_index, first_source, second_source,
               immediate, record_flag, overflow_enable,
        input  ready
    );
    modport sink (
        input  valid, command, dest_index, first_source, second_source,
               immediate, record_flag, overflow_enable,
        output ready
    );
endinterface

interface plu_out_if;
    logic           valid;
    logic           ready;
    plu_pkg::t_idx  written_index;
    plu_pkg::t_word written_value;
    logic           cr0_written;
    plu_pkg::t_cr   cr0_bits;
    logic           overflow_bit;
    logic           summary_overflow_bit;

    modport source (
        output valid, written_index, written_value, cr0_written, cr0_bits,
               overflow_bit, summary_overflow_bit,
        input  ready
    );
    modport sink (
        input  valid, written_index, written_value, cr0_written, cr0_bits,
               overflow_bit, summary_overflow_bit,
        output ready
    );
endinterface

@@ design/plu_ram.sv @@
module plu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

@@ design/plu_alu.sv @@
module plu_alu (
    input  plu_pkg::t_cmd        i_command,
    input  plu_pkg::t_imm        i_immediate,
    input  logic                 i_record_flag,
    input  logic                 i_overflow_enable,
    input  plu_pkg::t_word       i_first_value,
    input  plu_pkg::t_word       i_second_value,
    input  plu_pkg::t_flags      i_flags,
    output plu_pkg::t_alu_result o_result
);
    import plu_pkg::*;

    function automatic logic [CLZ_W-1:0] count_lead(input t_word v);
        t_word            x;
        logic [CLZ_W-1:0] n;
        x = v;
        n = '0;
        if (v == '0) begin
            n = CLZ_W'(DATA_W);
        end else begin
            if (x[31:16] == '0) begin
                n[4] = 1'b1;
                x = x << 16;
            end
            if (x[31:24] == '0) begin
                n[3] = 1'b1;
                x = x << 8;
            end
            if (x[31:28] == '0) begin
                n[2] = 1'b1;
                x = x << 4;
            end
            if (x[31:30] == '0) begin
                n[1] = 1'b1;
                x = x << 2;
            end
            if (!x[31]) begin
                n[0] = 1'b1;
            end
        end
        return n;
    endfunction

    t_word s;
    t_word b;
    t_word imm_lo;
    t_word imm_hi;
    t_word value;
    logic  write_en;
    logic  rec;
    logic  ov_next;
    logic  so_next;

    assign s      = i_first_value;
    assign b      = i_second_value;
    assign imm_lo = {{(DATA_W-IMM_W){1'b0}}, i_immediate};
    assign imm_hi = {i_immediate, {(DATA_W-IMM_W){1'b0}}};

    always_comb begin
        value    = '0;
        write_en = 1'b1;
        rec      = i_record_flag;
        ov_next  = i_flags.ov;
        so_next  = i_flags.so;
        case (i_command)
            CMD_ORI: begin
                value = s | imm_lo;
                rec   = 1'b0;
            end
            CMD_ORIS: begin
                value = s | imm_hi;
                rec   = 1'b0;
            end
            CMD_OR:   value = s | b;
            CMD_AND:  value = s & b;
            CMD_ANDI: begin
                value = s & imm_lo;
                rec   = 1'b1;
            end
            CMD_ANDIS: begin
                value = s & imm_hi;
                rec   = 1'b1;
            end
            CMD_NOR:  value = ~(s | b);
            CMD_ANDC: value = s & ~b;
            CMD_XOR:  value = s ^ b;
            CMD_XORI: begin
                value = s ^ imm_lo;
                rec   = 1'b0;
            end
            CMD_XORIS: begin
                value = s ^ imm_hi;
                rec   = 1'b0;
            end
            CMD_NEG: begin
                value = ~s + t_word'(1);
                if (i_overflow_enable) begin
                    ov_next = (s == MOST_NEGATIVE);
                    so_next = i_flags.so | (s == MOST_NEGATIVE);
                end
            end
            CMD_EXTSH: value = {{(DATA_W-16){s[15]}}, s[15:0]};
            CMD_EXTSB: value = {{(DATA_W-8){s[7]}}, s[7:0]};
            CMD_CNTLZW: value = {{(DATA_W-CLZ_W){1'b0}}, count_lead(s)};
            default: begin
                write_en = 1'b0;
                rec      = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_result.value    = value;
        o_result.write_en = write_en;
        o_result.rec      = rec;
        o_result.flags.ov = ov_next;
        o_result.flags.so = so_next;
        if (rec) begin
            o_result.flags.cr0 = {value[DATA_W-1], !value[DATA_W-1] && (value != '0),
                                  value == '0, so_next};
        end else begin
            o_result.flags.cr0 = i_flags.cr0;
        end
    end
endmodule

@@ design/powerpc_logical_execute_unit_core.sv @@
// Logical execute unit for decoded PowerPC integer logical instructions.
// i_cmd carries one decoded instruction per item (command, register indexes,
// immediate, Rc and OE bits); o_res returns one item per instruction with the
// written register, its new value, CR0 and the XER OV/SO bits after it.
// Both channels use valid/ready; an item moves when both are high.
// The accepting edge registers the item and also the register file read (a
// two-port RAM with registered read); the ALU computes from that read stage
// and its result is loaded into the output register when the stage advances.
// Throughput is one item per cycle while o_res does not stall; a result
// written back is forwarded to the following item.
// Reset clears the register file (per-entry valid bits), CR0, OV and SO and
// empties both stages; items are taken once reset is released.
// When o_res stalls, the output register holds its item, the read stage holds
// one more, and i_cmd.ready drops once both are full.
module powerpc_logical_execute_unit_core #(
    parameter int REG_COUNT = plu_pkg::REG_COUNT_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plu_in_if.sink    i_cmd,
    plu_out_if.source o_res
);
    import plu_pkg::*;

    localparam int ADDR_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic                 in_fire;
    logic                 advance;
    logic                 s1_fire;
    logic                 r_s1_valid;
    t_item                r_s1;
    logic                 r_hit_a;
    logic                 r_hit_b;
    t_word                r_byp;
    logic [REG_COUNT-1:0] r_valid;
    t_flags               r_flags;
    logic                 r_out_valid;
    t_result              r_out;

    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [ADDR_W-1:0] waddr;
    logic              we;
    t_word             rdata_a;
    t_word             rdata_b;
    t_word             val_a;
    t_word             val_b;
    logic              a_in_range;
    logic              b_in_range;
    logic              d_in_range;
    t_alu_result       alu;

    assign advance     = !r_out_valid || o_res.ready;
    assign s1_fire     = r_s1_valid && advance;
    assign i_cmd.ready = !r_s1_valid || advance;
    assign in_fire     = i_cmd.valid && i_cmd.ready;

    assign raddr_a = in_fire ? i_cmd.first_source[ADDR_W-1:0]  : r_s1.first_source[ADDR_W-1:0];
    assign raddr_b = in_fire ? i_cmd.second_source[ADDR_W-1:0] : r_s1.second_source[ADDR_W-1:0];

    assign a_in_range = 32'(r_s1.first_source) < 32'(REG_COUNT);
    assign b_in_range = 32'(r_s1.second_source) < 32'(REG_COUNT);
    assign d_in_range = 32'(r_s1.dest_index) < 32'(REG_COUNT);

    assign waddr = r_s1.dest_index[ADDR_W-1:0];
    assign we    = s1_fire && alu.write_en && d_in_range;

    plu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (alu.value),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        if (r_hit_a) begin
            val_a = r_byp;
        end else if (a_in_range && r_valid[r_s1.first_source[ADDR_W-1:0]]) begin
            val_a = rdata_a;
        end else begin
            val_a = '0;
        end
        if (r_hit_b) begin
            val_b = r_byp;
        end else if (b_in_range && r_valid[r_s1.second_source[ADDR_W-1:0]]) begin
            val_b = rdata_b;
        end else begin
            val_b = '0;
        end
    end

    plu_alu u_alu (
        .i_command         (r_s1.command),
        .i_immediate       (r_s1.immediate),
        .i_record_flag     (r_s1.record_flag),
        .i_overflow_enable (r_s1.overflow_enable),
        .i_first_value     (val_a),
        .i_second_value    (val_b),
        .i_flags           (r_flags),
        .o_result          (alu)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_flags     <= '0;
        end else begin
            if (i_cmd.ready) begin
                r_s1_valid <= in_fire;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (s1_fire) begin
                r_flags <= alu.flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.command         <= i_cmd.command;
            r_s1.dest_index      <= i_cmd.dest_index;
            r_s1.first_source    <= i_cmd.first_source;
            r_s1.second_source   <= i_cmd.second_source;
            r_s1.immediate       <= i_cmd.immediate;
            r_s1.record_flag     <= i_cmd.record_flag;
            r_s1.overflow_enable <= i_cmd.overflow_enable;
            r_hit_a <= we && (i_cmd.first_source == r_s1.dest_index);
            r_hit_b <= we && (i_cmd.second_source == r_s1.dest_index);
        end
        if (we) begin
            r_byp <= alu.value;
        end
        if (s1_fire) begin
            r_out.written_index        <= r_s1.dest_index;
            r_out.written_value        <= alu.value;
            r_out.cr0_written          <= alu.rec;
            r_out.cr0_bits             <= alu.flags.cr0;
            r_out.overflow_bit         <= alu.flags.ov;
            r_out.summary_overflow_bit <= alu.flags.so;
        end
    end

    assign o_res.valid                = r_out_valid;
    assign o_res.written_index        = r_out.written_index;
    assign o_res.written_value        = r_out.written_value;
    assign o_res.cr0_written          = r_out.cr0_written;
    assign o_res.cr0_bits             = r_out.cr0_bits;
    assign o_res.overflow_bit         = r_out.overflow_bit;
    assign o_res.summary_overflow_bit = r_out.summary_overflow_bit;
endmodule
